// ----- design/vmc_pkg.sv -----
// Shared types and codes for the view matrix camera.
package vmc_pkg;

	typedef logic [2:0][31:0] vec3_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_DIFF,
		ST_NABS,
		ST_NSHIFT,
		ST_NSQ,
		ST_NSQRT,
		ST_NDIV,
		ST_CROSS,
		ST_DOT,
		ST_OUT
	} vmc_state_t;

	localparam logic [2:0] CMD_ROT_SIDE  = 3'd0;
	localparam logic [2:0] CMD_ROT_UP    = 3'd1;
	localparam logic [2:0] CMD_MOVE_FWD  = 3'd2;
	localparam logic [2:0] CMD_MOVE_SIDE = 3'd3;
	localparam logic [2:0] CMD_MOVE_UP   = 3'd4;

	localparam logic [1:0] CFG_UP_X = 2'd0;
	localparam logic [1:0] CFG_UP_Y = 2'd1;
	localparam logic [1:0] CFG_UP_Z = 2'd2;

	localparam logic [6:0] SQRT_LAST = 7'd31;
	localparam logic [6:0] DIV_DONE  = 7'd64;

endpackage

// ----- design/view_matrix_camera.sv -----
// Look-at camera: applies motion commands and emits the 4x4 view matrix.
//
// Input channel (in_valid/in_stall) takes one word per command: req_type and
// a signed Q amount. Rotate commands move the target along side or up; move
// commands shift eye and target along forward, side or up. Codes above move
// up only rebuild the basis. Each command then yields four output words on
// out_valid/out_stall, one matrix column each, column_index 0..3, with
// last_column set on the translation column.
// The block takes one command at a time and holds in_stall high until the
// fourth column has been taken. Each normalization runs up to 29 one-bit
// scaling steps, a sum of squares, a 32-step square root and a restoring
// divide per component on one shared divider. A zero-length vector skips
// its normalization. All products share one registered 32x32 multiplier.
// When the receiver stalls, the current column holds and the block waits.
// Reset puts the eye at (0,0,1), the target at the origin, the basis to the
// default frame and world up to (0,1,0). The cfg channel (always ready)
// writes world_up_x/y/z. Writes take effect at the next command only if the
// user makes them between commands; the block itself does not enforce this.
module view_matrix_camera #(
	parameter int FRAC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  amount,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          column_index,
	output logic signed [31:0]  elem_row0,
	output logic signed [31:0]  elem_row1,
	output logic signed [31:0]  elem_row2,
	output logic signed [31:0]  elem_row3,
	output logic                last_column,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [31:0] Q_ONE = 32'd1 << FRAC_BITS;
	localparam logic [31:0] Q_NEG_ONE = ~Q_ONE + 32'd1;

	function automatic logic [31:0] qadd(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return s[31:0];
	endfunction

	function automatic logic [31:0] qsub(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return s[31:0];
	endfunction

	function automatic logic [31:0] qmsat(logic [63:0] p);
		logic signed [63:0] sh;
		sh = $signed(p) >>> FRAC_BITS;
		if (sh > $signed(64'h0000_0000_7FFF_FFFF))
			return 32'h7FFF_FFFF;
		if (sh < $signed(64'hFFFF_FFFF_8000_0000))
			return 32'h8000_0000;
		return sh[31:0];
	endfunction

	function automatic logic [31:0] pick3(vmc_pkg::vec3_t v, logic [1:0] i);
		logic [31:0] r;
		unique case (i)
			2'd0: r = v[0];
			2'd1: r = v[1];
			default: r = v[2];
		endcase
		return r;
	endfunction

	function automatic logic [1:0] rot1(logic [1:0] i);
		logic [1:0] r;
		unique case (i)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] rot2(logic [1:0] i);
		logic [1:0] r;
		unique case (i)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	vmc_pkg::vmc_state_t state_q, state_d;

	logic [1:0] ph_q;
	logic [1:0] comp_q;
	logic [1:0] grp_q;
	logic [6:0] cnt_q;
	logic       nsel_q;

	vmc_pkg::vec3_t eye_q, tgt_q, fwd_q, side_q, up_q, wu_q;

	logic [2:0]  req_q;
	logic [31:0] amount_q;
	vmc_pkg::vec3_t vec_q, mag_q, dres_q;
	logic [2:0]  neg_q;
	logic [63:0] sum_q, r_q, bit_q, num_q, rem_q, quo_q;
	logic [31:0] t1_q, acc_q;
	logic [63:0] prod_q;

	logic signed [31:0] mul_a, mul_b;
	logic [31:0] m_max, stp, xres, nres, dterm, dacc, qv;
	logic        m_zero, m_low, m_high, move_eye, div_ge;
	logic [63:0] sq_rb, div_t;
	vmc_pkg::vec3_t axis, av, bv, basis;

	assign cfg_ready = 1'b1;

	// datapath helpers
	always_comb begin
		m_max = mag_q[0];
		if (mag_q[1] > m_max)
			m_max = mag_q[1];
		if (mag_q[2] > m_max)
			m_max = mag_q[2];
		m_zero = (m_max == 32'd0);
		m_low  = (m_max[31:29] == 3'd0);
		m_high = |m_max[31:30];

		priority case (req_q)
			vmc_pkg::CMD_ROT_UP, vmc_pkg::CMD_MOVE_UP: axis = up_q;
			vmc_pkg::CMD_MOVE_FWD: axis = fwd_q;
			default: axis = side_q;
		endcase
		move_eye = (req_q != vmc_pkg::CMD_ROT_SIDE) && (req_q != vmc_pkg::CMD_ROT_UP);
		stp = qmsat(prod_q);

		av = nsel_q ? side_q : fwd_q;
		bv = nsel_q ? fwd_q : wu_q;
		xres = qsub(t1_q, qmsat(prod_q));

		sq_rb = r_q + bit_q;
		div_t = {rem_q[62:0], num_q[63]};
		div_ge = (div_t >= r_q);
		qv = quo_q[31:0];
		nres = neg_q[comp_q] ? (~qv + 32'd1) : qv;

		unique case (grp_q)
			2'd0: basis = side_q;
			2'd1: basis = up_q;
			default: basis = fwd_q;
		endcase
		dterm = qmsat(prod_q);
		dacc = (comp_q == 2'd0) ? dterm : qadd(acc_q, dterm);
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			vmc_pkg::ST_DISP: begin
				mul_a = amount_q;
				mul_b = pick3(axis, comp_q);
			end
			vmc_pkg::ST_NSQ: begin
				mul_a = pick3(mag_q, comp_q);
				mul_b = pick3(mag_q, comp_q);
			end
			vmc_pkg::ST_CROSS: begin
				if (ph_q == 2'd0) begin
					mul_a = pick3(av, rot1(comp_q));
					mul_b = pick3(bv, rot2(comp_q));
				end else begin
					mul_a = pick3(av, rot2(comp_q));
					mul_b = pick3(bv, rot1(comp_q));
				end
			end
			vmc_pkg::ST_DOT: begin
				mul_a = pick3(basis, comp_q);
				mul_b = pick3(eye_q, comp_q);
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vmc_pkg::ST_IDLE:
				if (in_valid)
					state_d = (req_type > vmc_pkg::CMD_MOVE_UP) ? vmc_pkg::ST_DIFF
						: vmc_pkg::ST_DISP;
			vmc_pkg::ST_DISP:
				if (ph_q[0] && comp_q == 2'd2)
					state_d = vmc_pkg::ST_DIFF;
			vmc_pkg::ST_DIFF:
				state_d = vmc_pkg::ST_NABS;
			vmc_pkg::ST_NABS:
				state_d = vmc_pkg::ST_NSHIFT;
			vmc_pkg::ST_NSHIFT:
				priority if (m_zero)
					state_d = vmc_pkg::ST_CROSS;
				else if (!m_low && !m_high)
					state_d = vmc_pkg::ST_NSQ;
				else
					state_d = vmc_pkg::ST_NSHIFT;
			vmc_pkg::ST_NSQ:
				if (ph_q[0] && comp_q == 2'd2)
					state_d = vmc_pkg::ST_NSQRT;
			vmc_pkg::ST_NSQRT:
				if (cnt_q == vmc_pkg::SQRT_LAST)
					state_d = vmc_pkg::ST_NDIV;
			vmc_pkg::ST_NDIV:
				if (cnt_q == vmc_pkg::DIV_DONE && comp_q == 2'd2)
					state_d = vmc_pkg::ST_CROSS;
			vmc_pkg::ST_CROSS:
				if (ph_q == 2'd2 && comp_q == 2'd2)
					state_d = nsel_q ? vmc_pkg::ST_DOT : vmc_pkg::ST_NABS;
			vmc_pkg::ST_DOT:
				if (ph_q[0] && comp_q == 2'd2 && grp_q == 2'd2)
					state_d = vmc_pkg::ST_OUT;
			vmc_pkg::ST_OUT:
				if (!out_stall && grp_q == 2'd3)
					state_d = vmc_pkg::ST_IDLE;
			default:
				state_d = vmc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = (state_q != vmc_pkg::ST_IDLE);
		out_valid    = (state_q == vmc_pkg::ST_OUT);
		column_index = grp_q;
		last_column  = (grp_q == 2'd3);
		if (grp_q == 2'd3) begin
			elem_row0 = dres_q[0];
			elem_row1 = dres_q[1];
			elem_row2 = dres_q[2];
			elem_row3 = Q_ONE;
		end else begin
			elem_row0 = pick3(side_q, grp_q);
			elem_row1 = pick3(up_q, grp_q);
			elem_row2 = qsub(32'd0, pick3(fwd_q, grp_q));
			elem_row3 = '0;
		end
	end

	// control and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vmc_pkg::ST_IDLE;
			ph_q    <= '0;
			comp_q  <= '0;
			grp_q   <= '0;
			cnt_q   <= '0;
			nsel_q  <= 1'b0;
			eye_q   <= {Q_ONE, 32'd0, 32'd0};
			tgt_q   <= '0;
			fwd_q   <= {Q_NEG_ONE, 32'd0, 32'd0};
			side_q  <= {32'd0, 32'd0, Q_ONE};
			up_q    <= {32'd0, Q_ONE, 32'd0};
			wu_q    <= {32'd0, Q_ONE, 32'd0};
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					vmc_pkg::CFG_UP_X: wu_q[0] <= cfg_data;
					vmc_pkg::CFG_UP_Y: wu_q[1] <= cfg_data;
					vmc_pkg::CFG_UP_Z: wu_q[2] <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				vmc_pkg::ST_IDLE:
					if (in_valid) begin
						ph_q   <= '0;
						comp_q <= '0;
						grp_q  <= '0;
						cnt_q  <= '0;
						nsel_q <= 1'b0;
					end
				vmc_pkg::ST_DISP:
					if (!ph_q[0]) begin
						ph_q <= 2'd1;
					end else begin
						tgt_q[comp_q] <= qadd(pick3(tgt_q, comp_q), stp);
						if (move_eye)
							eye_q[comp_q] <= qadd(pick3(eye_q, comp_q), stp);
						ph_q   <= 2'd0;
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					end
				vmc_pkg::ST_NSHIFT:
					if (m_zero) begin
						if (nsel_q)
							side_q <= '0;
						else
							fwd_q <= '0;
						comp_q <= '0;
						ph_q   <= '0;
					end else if (!m_low && !m_high) begin
						comp_q <= '0;
						ph_q   <= '0;
					end
				vmc_pkg::ST_NSQ:
					if (!ph_q[0]) begin
						ph_q <= 2'd1;
					end else begin
						ph_q   <= 2'd0;
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
						cnt_q  <= '0;
					end
				vmc_pkg::ST_NSQRT:
					if (cnt_q == vmc_pkg::SQRT_LAST) begin
						cnt_q  <= '0;
						comp_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				vmc_pkg::ST_NDIV:
					if (cnt_q == vmc_pkg::DIV_DONE) begin
						if (nsel_q)
							side_q[comp_q] <= nres;
						else
							fwd_q[comp_q] <= nres;
						cnt_q  <= '0;
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
						ph_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				vmc_pkg::ST_CROSS:
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 2'd1;
					end else begin
						if (nsel_q)
							up_q[comp_q] <= xres;
						ph_q <= '0;
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							grp_q  <= '0;
							nsel_q <= 1'b1;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				vmc_pkg::ST_DOT:
					if (!ph_q[0]) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							grp_q  <= (grp_q == 2'd2) ? 2'd0 : grp_q + 2'd1;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				vmc_pkg::ST_OUT:
					if (!out_stall)
						grp_q <= grp_q + 2'd1;
				default: ;
			endcase
		end
	end

	// scratch datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			vmc_pkg::ST_IDLE:
				if (in_valid) begin
					req_q    <= req_type;
					amount_q <= amount;
				end
			vmc_pkg::ST_DIFF:
				for (int i = 0; i < 3; i++)
					vec_q[i] <= qsub(tgt_q[i], eye_q[i]);
			vmc_pkg::ST_NABS:
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= vec_q[i][31];
					mag_q[i] <= vec_q[i][31] ? (~vec_q[i] + 32'd1) : vec_q[i];
				end
			vmc_pkg::ST_NSHIFT:
				if (!m_zero) begin
					priority if (m_low) begin
						for (int i = 0; i < 3; i++)
							mag_q[i] <= {mag_q[i][30:0], 1'b0};
					end else if (m_high) begin
						for (int i = 0; i < 3; i++)
							mag_q[i] <= {1'b0, mag_q[i][31:1]};
					end else begin
						sum_q <= '0;
					end
				end
			vmc_pkg::ST_NSQ:
				if (ph_q[0]) begin
					sum_q <= sum_q + prod_q;
					r_q   <= '0;
					bit_q <= 64'd1 << 62;
				end
			vmc_pkg::ST_NSQRT: begin
				if (sum_q >= sq_rb) begin
					sum_q <= sum_q - sq_rb;
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				num_q <= 64'(mag_q[0]) << FRAC_BITS;
				rem_q <= '0;
			end
			vmc_pkg::ST_NDIV:
				if (cnt_q == vmc_pkg::DIV_DONE) begin
					num_q <= 64'(pick3(mag_q, rot1(comp_q))) << FRAC_BITS;
					rem_q <= '0;
				end else begin
					num_q <= {num_q[62:0], 1'b0};
					rem_q <= div_ge ? (div_t - r_q) : div_t;
					quo_q <= {quo_q[62:0], div_ge};
				end
			vmc_pkg::ST_CROSS: begin
				if (ph_q == 2'd1)
					t1_q <= qmsat(prod_q);
				if (ph_q == 2'd2 && !nsel_q)
					vec_q[comp_q] <= xres;
			end
			vmc_pkg::ST_DOT:
				if (ph_q[0]) begin
					acc_q <= dacc;
					if (comp_q == 2'd2)
						dres_q[grp_q] <= (grp_q == 2'd2) ? dacc : qsub(32'd0, dacc);
				end
			default: ;
		endcase
	end

	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a second command while busy");

	ap_no_early_column: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("column shown before the basis was rebuilt");

	ap_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_column |=> !out_valid && !in_stall)
		else $error("block did not return to idle after the last column");

	ap_unit_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vmc_pkg::ST_NDIV && cnt_q == vmc_pkg::DIV_DONE
		|-> quo_q <= 64'(Q_ONE))
		else $error("normalized component exceeds one");

endmodule

// ----- verif/view_matrix_camera_tb.sv -----
// Testbench for view_matrix_camera: directed and random camera commands checked against a look-at matrix model.
module view_matrix_camera_tb;

	localparam int FB = 20;
	localparam int ONE = 1 << FB;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] r0;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
		logic        last;
	} column_t;

	typedef struct packed {
		logic [2:0]  req;
		logic [31:0] amt;
	} cmd_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic signed [31:0] amount = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] column_index;
	logic signed [31:0] elem_row0, elem_row1, elem_row2, elem_row3;
	logic last_column;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	view_matrix_camera dut (.*);

	always #2 clk = ~clk;

	cmd_t cmd_q[$];
	column_t matrix_cols_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cmds_done = 0;
	int cols_seen = 0;
	int cycles = 0;

	// camera model state
	vmc_pkg::vec3_t eye, tgt, fwd, side, upv, wup;

	function automatic int sat(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int qmul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		if (p >= 0) return sat(p >>> FB);
		return sat(-(((-p) + (64'sd1 << FB) - 1) >>> FB));
	endfunction

	function automatic int qadd(int a, int b);
		return sat(longint'(a) + longint'(b));
	endfunction

	function automatic int qsub(int a, int b);
		return sat(longint'(a) - longint'(b));
	endfunction

	function automatic int dot(vmc_pkg::vec3_t a, vmc_pkg::vec3_t b);
		int s;
		s = qmul(a[0], b[0]);
		s = qadd(s, qmul(a[1], b[1]));
		return qadd(s, qmul(a[2], b[2]));
	endfunction

	function automatic vmc_pkg::vec3_t cross_prod(vmc_pkg::vec3_t a, vmc_pkg::vec3_t b);
		vmc_pkg::vec3_t o;
		o[0] = qsub(qmul(a[1], b[2]), qmul(a[2], b[1]));
		o[1] = qsub(qmul(a[2], b[0]), qmul(a[0], b[2]));
		o[2] = qsub(qmul(a[0], b[1]), qmul(a[1], b[0]));
		return o;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic vmc_pkg::vec3_t unit_vec(vmc_pkg::vec3_t v);
		longint unsigned mag[3];
		longint unsigned m, sum, len, q;
		bit neg[3];
		int s;
		vmc_pkg::vec3_t o;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			s = v[i];
			neg[i] = s < 0;
			mag[i] = neg[i] ? longint'(-longint'(s)) : longint'(s);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) return '0;
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << FB) / len;
			o[i] = neg[i] ? 32'(-longint'(q)) : 32'(q);
		end
		return o;
	endfunction

	function automatic void apply_camera_cmd(logic [2:0] req, int amt);
		vmc_pkg::vec3_t axis, d;
		bit moves, has_axis;
		column_t c;
		moves = 1;
		has_axis = 1;
		case (req)
			vmc_pkg::CMD_ROT_SIDE: begin axis = side; moves = 0; end
			vmc_pkg::CMD_ROT_UP: begin axis = upv; moves = 0; end
			vmc_pkg::CMD_MOVE_FWD: axis = fwd;
			vmc_pkg::CMD_MOVE_SIDE: axis = side;
			vmc_pkg::CMD_MOVE_UP: axis = upv;
			default: has_axis = 0;
		endcase
		if (has_axis) begin
			for (int i = 0; i < 3; i++) begin
				tgt[i] = qadd(tgt[i], qmul(amt, axis[i]));
				if (moves) eye[i] = qadd(eye[i], qmul(amt, axis[i]));
			end
		end
		for (int i = 0; i < 3; i++) d[i] = qsub(tgt[i], eye[i]);
		fwd = unit_vec(d);
		side = unit_vec(cross_prod(fwd, wup));
		upv = cross_prod(side, fwd);
		for (int k = 0; k < 3; k++) begin
			c = '{idx: 2'(k), r0: side[k], r1: upv[k], r2: sat(-longint'($signed(fwd[k]))),
				r3: 0, last: 0};
			matrix_cols_q.push_back(c);
		end
		c = '{idx: 2'd3, r0: sat(-longint'(dot(side, eye))),
			r1: sat(-longint'(dot(upv, eye))), r2: dot(fwd, eye), r3: ONE, last: 1};
		matrix_cols_q.push_back(c);
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_camera_cmd(req_type, amount);
				cmds_done++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_t c;
					c = cmd_q.pop_front();
					in_valid <= 1;
					req_type <= c.req;
					amount <= c.amt;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// column monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				column_t got, want;
				got = '{idx: column_index, r0: elem_row0, r1: elem_row1, r2: elem_row2,
					r3: elem_row3, last: last_column};
				cols_seen++;
				if (matrix_cols_q.size() == 0) begin
					$display("%0t: unexpected column word %h", $time, got);
					errors++;
				end else begin
					want = matrix_cols_q.pop_front();
					if (got.idx !== want.idx || got.r0 !== want.r0 || got.r1 !== want.r1 ||
						got.r2 !== want.r2 || got.r3 !== want.r3 ||
						got.last !== want.last) begin
						$display("%0t: column mismatch exp %h got %h", $time, want, got);
						errors++;
					end
				end
			end
			out_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_up(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		wup[idx] = val;
		cfg_valid <= 0;
	endtask

	task automatic set_up(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		write_up(vmc_pkg::CFG_UP_X, x);
		write_up(vmc_pkg::CFG_UP_Y, y);
		write_up(vmc_pkg::CFG_UP_Z, z);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_q.size() > 0 || in_valid || matrix_cols_q.size() > 0);
	endtask

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
		endcase
	endfunction

	function automatic logic [31:0] rand_up();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			2: return 0;
			default: return 32'($signed($urandom_range(2 * ONE)) - ONE);
		endcase
	endfunction

	initial begin
		eye = '0;
		eye[2] = ONE;
		tgt = '0;
		fwd = '0;
		fwd[2] = -ONE;
		side = '0;
		side[0] = ONE;
		upv = '0;
		upv[1] = ONE;
		wup = '0;
		wup[1] = ONE;
		send_idle_pct = 20;
		recv_stall_pct = 67;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: every code, amount extremes
		for (int r = 0; r < 8; r++) cmd_q.push_back('{3'(r), 32'(ONE / 2)});
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_FWD, 32'h0});
		cmd_q.push_back('{vmc_pkg::CMD_ROT_SIDE, 32'h1});
		cmd_q.push_back('{vmc_pkg::CMD_ROT_UP, 32'hffffffff});
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_SIDE, 32'h7fffffff});
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_UP, 32'h80000000});
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_FWD, 32'h80000000});
		cmd_q.push_back('{vmc_pkg::CMD_ROT_SIDE, 32'h7fffffff});
		wait_drained();
		// world up set to z, then to zero: a zero world up collapses side to zero
		set_up(0, 0, ONE);
		cmd_q.push_back('{vmc_pkg::CMD_ROT_UP, 32'(ONE)});
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_SIDE, 32'(-ONE)});
		wait_drained();
		set_up(0, 0, 0);
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_FWD, 32'(ONE)});
		cmd_q.push_back('{3'd7, 32'h5a5a5a5a});
		wait_drained();
		set_up(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		cmd_q.push_back('{vmc_pkg::CMD_MOVE_UP, 32'(ONE)});
		cmd_q.push_back('{vmc_pkg::CMD_ROT_SIDE, 32'(-3 * ONE)});
		wait_drained();

		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 67;
				recv_stall_pct = 20;
			end else if (ph == 8) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if (ph == 0) set_up(0, ONE, 0);
			else set_up(rand_up(), rand_up(), rand_up());
			for (int n = 0; n < 30; n++) begin
				cmd_t c;
				c.req = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(vmc_pkg::CMD_MOVE_UP));
				c.amt = rand_amount();
				cmd_q.push_back(c);
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		$display("covered %0d commands, %0d matrix columns, 14 world-up settings",
			cmds_done, cols_seen);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
